// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the line rasterizer.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lr_pkg.sv =====
// Types, constants and the microcode table of the line rasterizer.
// Depends on nothing; used by the interfaces, the sequencer and the core.
`default_nettype none

package lr_pkg;

  localparam int unsigned X_W   = 10;
  localparam int unsigned Y_W   = 9;
  localparam int unsigned C_W   = 8;
  localparam int unsigned LIM_W = 13;  // holds frame limits up to 8191
  localparam int unsigned PROD_W = 19; // row span times column offset
  localparam int unsigned DIV_STEPS = 10;
  localparam int unsigned CNT_W = 4;

  localparam logic OPERATION_START   = 1'b0;
  localparam logic OPERATION_ADVANCE = 1'b1;

  localparam logic [1:0] MODE_SLOPED   = 2'd0;
  localparam logic [1:0] MODE_VERTICAL = 2'd1;
  localparam logic [1:0] MODE_POINT    = 2'd2;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ACCEPT = 3'd0;
  localparam step_t STEP_DECODE = 3'd1;
  localparam step_t STEP_ROUTE  = 3'd2;
  localparam step_t STEP_MUL    = 3'd3;
  localparam step_t STEP_DIV    = 3'd4;
  localparam step_t STEP_FIX    = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;
  localparam step_t STEP_RETRY  = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_DECODE,
    OP_MUL,
    OP_DIV,
    OP_FIX,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_NO_LINE,
    C_NOT_SLOPED,
    C_DIV_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } lr_ctrl_t;

  typedef struct packed {
    logic no_input;
    logic no_line;
    logic not_sloped;
    logic div_more;
    logic out_free;
  } lr_flags_t;

  // Microcode: one control word per step. A taken condition jumps to the
  // target, otherwise the step counter advances by one.
  function automatic lr_ctrl_t ucode(input step_t step);
    lr_ctrl_t w;
    case (step)
      STEP_ACCEPT: w = '{OP_ACCEPT, C_NO_INPUT,   STEP_ACCEPT};
      STEP_DECODE: w = '{OP_DECODE, C_NO_LINE,    STEP_ACCEPT};
      STEP_ROUTE:  w = '{OP_IDLE,   C_NOT_SLOPED, STEP_EMIT};
      STEP_MUL:    w = '{OP_MUL,    C_NEXT,       STEP_ACCEPT};
      STEP_DIV:    w = '{OP_DIV,    C_DIV_MORE,   STEP_DIV};
      STEP_FIX:    w = '{OP_FIX,    C_NEXT,       STEP_ACCEPT};
      STEP_EMIT:   w = '{OP_EMIT,   C_OUT_FREE,   STEP_ACCEPT};
      STEP_RETRY:  w = '{OP_IDLE,   C_ALWAYS,     STEP_EMIT};
      default:     w = '{OP_IDLE,   C_ALWAYS,     STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lr_if.sv =====
// Handshake interfaces for the input words and the pixel words.
// Depends on lr_pkg for the field widths.
`default_nettype none

interface lr_item_if;
  import lr_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [X_W-1:0]   x_start;
  logic [Y_W-1:0]   y_start;
  logic [X_W-1:0]   x_end;
  logic [Y_W-1:0]   y_end;
  logic [C_W-1:0]   red_in;
  logic [C_W-1:0]   green_in;
  logic [C_W-1:0]   blue_in;

  modport source (output valid, operation, x_start, y_start, x_end, y_end,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, operation, x_start, y_start, x_end, y_end,
                red_in, green_in, blue_in, output ready);
endinterface

interface lr_pixel_if;
  import lr_pkg::*;
  logic             valid;
  logic             ready;
  logic [X_W-1:0]   pixel_x;
  logic [Y_W-1:0]   pixel_y;
  logic [C_W-1:0]   red_out;
  logic [C_W-1:0]   green_out;
  logic [C_W-1:0]   blue_out;
  logic             last_pixel;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lr_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on lr_pkg for the control word, the flags and the program.
`default_nettype none

module lr_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lr_pkg::lr_flags_t flags_i,
  output lr_pkg::lr_ctrl_t       ctrl_o
);
  import lr_pkg::*;

  step_t    step_q, step_d;
  lr_ctrl_t ctrl;
  logic     take;

  always_comb begin
    ctrl = ucode(step_q);
    case (ctrl.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_INPUT:   take = flags_i.no_input;
      C_NO_LINE:    take = flags_i.no_line;
      C_NOT_SLOPED: take = flags_i.not_sloped;
      C_DIV_MORE:   take = flags_i.div_more;
      C_OUT_FREE:   take = flags_i.out_free;
      default:      take = 1'b0;
    endcase
    step_d = take ? ctrl.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer_core.sv =====
// Line rasterizer core: a start word loads two endpoints and a color and yields the
// first pixel of the line; each advance word yields the next pixel, and the final
// pixel carries last_pixel. Sloped lines walk x upward from the smaller column to
// the larger and take y = y0 + (y1-y0)*(x-x0)/(x1-x0), truncated toward zero, so
// steep lines show gaps; vertical lines walk y upward over both endpoints; equal
// endpoints give a single pixel. Endpoints beyond the frame saturate to the last
// column or row on start. An advance word with no line running is consumed and
// yields nothing. The core handles one word at a time under a small microcode
// program: a sloped word passes through accept, decode, route, multiply, ten
// restoring-division steps, row fix-up and emit, and the emit step writes its
// pixel into the pixel register; a vertical or single-point word passes through
// accept, decode, route and emit, and a dropped advance word through accept and
// decode only. Input ready is high only in the accept step; a finished pixel
// sits in the output register while the next word is already being worked on,
// and the emit step waits only if that register is still occupied, passing
// through the retry step before each new try.
// Depends on lr_pkg, lr_if.sv and lr_sequencer.
`default_nettype none

module line_rasterizer_core #(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lr_item_if.sink     item_i,
  lr_pixel_if.source  pixel_o
);
  import lr_pkg::*;

  // Last valid column and row, used to saturate endpoints on start.
  localparam logic [LIM_W-1:0] XLast = LIM_W'(FRAME_WIDTH - 1);
  localparam logic [LIM_W-1:0] YLast = LIM_W'(FRAME_HEIGHT - 1);

  lr_ctrl_t  ctrl;
  lr_flags_t flags;

  // Captured input word.
  logic           op_q;
  logic [X_W-1:0] xs_q, xe_q;
  logic [Y_W-1:0] ys_q, ye_q;
  logic [3*C_W-1:0] color_in_q;

  // Line state.
  logic [X_W-1:0]   anchor_x_q, far_x_q, step_pos_q;
  logic [Y_W-1:0]   anchor_y_q, far_y_q;
  logic [1:0]       mode_q;
  logic             active_q;
  logic [3*C_W-1:0] color_q;

  // Interpolation datapath.
  logic [X_W-1:0]   dvd_q, rem_q, den_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [Y_W-1:0]   y_q;

  // Output register.
  logic             out_valid_q;
  logic [X_W-1:0]   out_x_q;
  logic [Y_W-1:0]   out_y_q;
  logic [3*C_W-1:0] out_color_q;
  logic             out_last_q;

  // Endpoint saturation for the start word.
  logic [X_W-1:0] ax_c, fx_c;
  logic [Y_W-1:0] ay_c, fy_c;

  // Multiply step: magnitudes of the row span, column offset and column span.
  logic [X_W:0]    dy_s;
  logic [X_W:0]    dt_s;
  logic [X_W:0]    dx_s;
  logic [Y_W-1:0]  dy_mag;
  logic [X_W-1:0]  dt_mag, dx_mag;
  logic [PROD_W-1:0] prod;

  // Division step.
  logic [X_W:0] trial, trial_sub;
  logic         fits;

  // Pixel selection.
  logic [X_W-1:0] px, end_pos;
  logic [Y_W-1:0] py;
  logic           is_last;
  logic           out_free;
  logic           emit;

  lr_sequencer u_lr_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign item_i.ready = (ctrl.op == OP_ACCEPT);

  always_comb begin
    ax_c = (LIM_W'(xs_q) > XLast) ? XLast[X_W-1:0] : xs_q;
    fx_c = (LIM_W'(xe_q) > XLast) ? XLast[X_W-1:0] : xe_q;
    ay_c = (LIM_W'(ys_q) > YLast) ? YLast[Y_W-1:0] : ys_q;
    fy_c = (LIM_W'(ye_q) > YLast) ? YLast[Y_W-1:0] : ye_q;
  end

  // The quotient never exceeds the row span, so the product's top bits are
  // already below the divisor and ten quotient bits are enough.
  always_comb begin
    dy_s   = (X_W+1)'(far_y_q) - (X_W+1)'(anchor_y_q);
    dt_s   = (X_W+1)'(step_pos_q) - (X_W+1)'(anchor_x_q);
    dx_s   = (X_W+1)'(far_x_q) - (X_W+1)'(anchor_x_q);
    dy_mag = dy_s[X_W] ? Y_W'(-dy_s) : dy_s[Y_W-1:0];
    dt_mag = dt_s[X_W] ? X_W'(-dt_s) : dt_s[X_W-1:0];
    dx_mag = dx_s[X_W] ? X_W'(-dx_s) : dx_s[X_W-1:0];
    prod   = PROD_W'(dy_mag) * PROD_W'(dt_mag);
  end

  always_comb begin
    trial     = {rem_q, dvd_q[X_W-1]};
    fits      = (trial >= (X_W+1)'(den_q));
    trial_sub = trial - (X_W+1)'(den_q);
  end

  always_comb begin
    case (mode_q)
      MODE_SLOPED: begin
        px      = step_pos_q;
        py      = y_q;
        end_pos = (anchor_x_q > far_x_q) ? anchor_x_q : far_x_q;
      end
      MODE_VERTICAL: begin
        px      = anchor_x_q;
        py      = step_pos_q[Y_W-1:0];
        end_pos = (anchor_y_q > far_y_q) ? X_W'(anchor_y_q) : X_W'(far_y_q);
      end
      default: begin
        px      = anchor_x_q;
        py      = anchor_y_q;
        end_pos = step_pos_q;
      end
    endcase
    is_last = (step_pos_q >= end_pos);
  end

  assign out_free = !out_valid_q || pixel_o.ready;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  always_comb begin
    flags.no_input   = !item_i.valid;
    flags.no_line    = (op_q == OPERATION_ADVANCE) && !active_q;
    flags.not_sloped = (mode_q != MODE_SLOPED);
    flags.div_more   = (cnt_q != '0);
    flags.out_free   = out_free;
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      op_q       <= item_i.operation;
      xs_q       <= item_i.x_start;
      ys_q       <= item_i.y_start;
      xe_q       <= item_i.x_end;
      ye_q       <= item_i.y_end;
      color_in_q <= {item_i.red_in, item_i.green_in, item_i.blue_in};
    end
  end

  // Line state: loaded on start, stepped on advance, retired on the last pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      far_x_q    <= '0;
      far_y_q    <= '0;
      step_pos_q <= '0;
      mode_q     <= MODE_SLOPED;
      active_q   <= 1'b0;
      color_q    <= '0;
    end else if (ctrl.op == OP_DECODE) begin
      if (op_q == OPERATION_START) begin
        anchor_x_q <= ax_c;
        anchor_y_q <= ay_c;
        far_x_q    <= fx_c;
        far_y_q    <= fy_c;
        color_q    <= color_in_q;
        active_q   <= 1'b1;
        if (ax_c != fx_c) begin
          mode_q     <= MODE_SLOPED;
          step_pos_q <= (ax_c < fx_c) ? ax_c : fx_c;
        end else if (ay_c != fy_c) begin
          mode_q     <= MODE_VERTICAL;
          step_pos_q <= (ay_c < fy_c) ? X_W'(ay_c) : X_W'(fy_c);
        end else begin
          mode_q     <= MODE_POINT;
          step_pos_q <= ax_c;
        end
      end else if (active_q) begin
        step_pos_q <= step_pos_q + 1'b1;
      end
    end else if (emit && is_last) begin
      active_q <= 1'b0;
    end
  end

  // Restoring divider: the dividend's bits shift out at the top as quotient bits
  // shift in at the bottom, so dvd_q holds the quotient after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl.op == OP_MUL) begin
      cnt_q <= CNT_W'(DIV_STEPS - 1);
    end else if (ctrl.op == OP_DIV) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      OP_MUL: begin
        rem_q <= X_W'(prod[PROD_W-1:X_W]);
        dvd_q <= prod[X_W-1:0];
        den_q <= dx_mag;
        neg_q <= dy_s[X_W];
      end
      OP_DIV: begin
        rem_q <= fits ? trial_sub[X_W-1:0] : trial[X_W-1:0];
        dvd_q <= {dvd_q[X_W-2:0], fits};
      end
      OP_FIX: begin
        y_q <= neg_q ? anchor_y_q - dvd_q[Y_W-1:0] : anchor_y_q + dvd_q[Y_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pixel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_color_q <= color_q;
      out_last_q  <= is_last;
    end
  end

  assign pixel_o.valid      = out_valid_q;
  assign pixel_o.pixel_x    = out_x_q;
  assign pixel_o.pixel_y    = out_y_q;
  assign pixel_o.red_out    = out_color_q[3*C_W-1:2*C_W];
  assign pixel_o.green_out  = out_color_q[2*C_W-1:C_W];
  assign pixel_o.blue_out   = out_color_q[C_W-1:0];
  assign pixel_o.last_pixel = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/lr_checker.sv =====
// Port-level checker for the line rasterizer core, bound to the core module.
// Depends on assert_macros.svh and the core's handshake ports.
`default_nettype none

`include "assert_macros.svh"

module lr_checker #(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       item_valid_i,
  input wire logic       item_ready_i,
  input wire logic       pix_valid_i,
  input wire logic       pix_ready_i,
  input wire logic [9:0] pixel_x_i,
  input wire logic [8:0] pixel_y_i
);

  // The core takes one word at a time, so ready drops right after a take.
  `LR_ASSERT_NEXT(a_one_word_at_a_time, item_valid_i && item_ready_i, !item_ready_i, "ready held after accept")

  // A pixel never rises straight out of an acceptance; the decode step lies between.
  `LR_ASSERT_NOW(a_no_instant_pixel, $rose(pix_valid_i), !$past(item_valid_i && item_ready_i), "pixel one cycle after accept")

  // Every emitted pixel lies inside the frame.
  `LR_ASSERT_NOW(a_pixel_in_frame, pix_valid_i, (pixel_x_i < FRAME_WIDTH) && (pixel_y_i < FRAME_HEIGHT), "pixel outside frame")

  // A stalled pixel word stays offered.
  `LR_ASSERT_NEXT(a_pixel_held, pix_valid_i && !pix_ready_i, pix_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i), "stalled pixel dropped")

endmodule

bind line_rasterizer_core lr_checker #(
  .FRAME_WIDTH  (FRAME_WIDTH),
  .FRAME_HEIGHT (FRAME_HEIGHT)
) u_lr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .pix_valid_i  (pixel_o.valid),
  .pix_ready_i  (pixel_o.ready),
  .pixel_x_i    (pixel_o.pixel_x),
  .pixel_y_i    (pixel_o.pixel_y)
);

`default_nettype wire

// ===== dv/line_rasterizer_core_test.sv =====
// Self-checking testbench for line_rasterizer_core: start and advance words in, pixel words out.
// Depends on lr_pkg, the lr_item_if and lr_pixel_if interfaces and the core itself.
`timescale 1ns / 1ps

module line_rasterizer_core_test;
  import lr_pkg::*;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;

  // The random part stops once this many words have produced a pixel.
  localparam int unsigned PIXEL_WORDS_WANTED = 1500;
  // This is far beyond the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Quiet cycles after the last expected pixel, to catch anything spurious.
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic           op;
    logic [X_W-1:0] xs;
    logic [Y_W-1:0] ys;
    logic [X_W-1:0] xe;
    logic [Y_W-1:0] ye;
    logic [C_W-1:0] r;
    logic [C_W-1:0] g;
    logic [C_W-1:0] b;
  } item_word_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [C_W-1:0] r;
    logic [C_W-1:0] g;
    logic [C_W-1:0] b;
    logic           last;
  } pixel_word_t;

  // How a directed row is checked: by the predictor, as producing nothing, or
  // against the pixel typed into the row (color taken from the row itself).
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    item_word_t     w;
    row_kind_e      kind;
    logic [X_W-1:0] px;
    logic [Y_W-1:0] py;
    logic           plast;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lr_item_if  item_bus ();
  lr_pixel_if pixel_bus ();

  line_rasterizer_core #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_bus),
    .pixel_o(pixel_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state. It mirrors the core after reset: everything zero and no
  // line running.
  logic [X_W-1:0]   anchor_col = '0;
  logic [Y_W-1:0]   anchor_row = '0;
  logic [X_W-1:0]   far_col    = '0;
  logic [Y_W-1:0]   far_row    = '0;
  logic [X_W-1:0]   walk_pos   = '0;
  logic [1:0]       shape      = MODE_SLOPED;
  logic             line_on    = 1'b0;
  logic [3*C_W-1:0] ink        = '0;

  pixel_word_t pixels_due[$];
  int unsigned pixel_words = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm_phase  = 1'b0;
  dir_row_t    directed_rows [23];

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  function automatic logic [X_W-1:0] sat_col(input logic [X_W-1:0] v);
    return (v > FRAME_WIDTH - 1) ? X_W'(FRAME_WIDTH - 1) : v;
  endfunction

  function automatic logic [Y_W-1:0] sat_row(input logic [Y_W-1:0] v);
    return (v > FRAME_HEIGHT - 1) ? Y_W'(FRAME_HEIGHT - 1) : v;
  endfunction

  // Advances the predictor by one accepted word. Returns 1 when the word yields
  // a pixel, which is then placed in px.
  function automatic bit rasterize_step(input item_word_t w, output pixel_word_t px);
    longint         a_row;
    longint         f_row;
    longint         a_col;
    longint         f_col;
    longint         pos;
    longint         row;
    logic [X_W-1:0] stop_at;

    if (w.op == OPERATION_START) begin
      // Endpoints saturate to the frame before anything else looks at them.
      anchor_col = sat_col(w.xs);
      anchor_row = sat_row(w.ys);
      far_col    = sat_col(w.xe);
      far_row    = sat_row(w.ye);
      ink        = {w.r, w.g, w.b};
      if (anchor_col != far_col) begin
        shape    = MODE_SLOPED;
        walk_pos = (anchor_col < far_col) ? anchor_col : far_col;
      end else if (anchor_row != far_row) begin
        shape    = MODE_VERTICAL;
        walk_pos = X_W'((anchor_row < far_row) ? anchor_row : far_row);
      end else begin
        shape    = MODE_POINT;
        walk_pos = anchor_col;
      end
      line_on = 1'b1;
    end else begin
      if (!line_on) return 1'b0;
      walk_pos = walk_pos + 1'b1;
    end

    case (shape)
      MODE_SLOPED: begin
        a_row = anchor_row;
        f_row = far_row;
        a_col = anchor_col;
        f_col = far_col;
        pos   = walk_pos;
        // Signed division of longints truncates toward zero, as the core does.
        row = (f_col != a_col) ? (f_row - a_row) * (pos - a_col) / (f_col - a_col) : 0;
        row = row + a_row;
        if (row < 0) row = 0;
        px.x    = walk_pos;
        px.y    = Y_W'(row);
        stop_at = (anchor_col > far_col) ? anchor_col : far_col;
      end
      MODE_VERTICAL: begin
        px.x    = anchor_col;
        px.y    = walk_pos[Y_W-1:0];
        stop_at = X_W'((anchor_row > far_row) ? anchor_row : far_row);
      end
      default: begin
        px.x    = anchor_col;
        px.y    = anchor_row;
        stop_at = walk_pos;
      end
    endcase

    px.last = (walk_pos >= stop_at);
    if (px.last) line_on = 1'b0;
    {px.r, px.g, px.b} = ink;
    return 1'b1;
  endfunction

  // Idle length for either side: mostly none, sometimes a few cycles, rarely long.
  function automatic int pick_idle();
    int roll;
    if (calm_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [X_W-1:0] pick_col();
    return X_W'(($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_WIDTH, 1023)
                                            : $urandom_range(0, FRAME_WIDTH - 1));
  endfunction

  function automatic logic [Y_W-1:0] pick_row();
    return Y_W'(($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_HEIGHT, 511)
                                            : $urandom_range(0, FRAME_HEIGHT - 1));
  endfunction

  // A column a short way off, now and then a long way off; stays in the field range.
  function automatic logic [X_W-1:0] near_col(input logic [X_W-1:0] c);
    int span;
    int v;
    span = ($urandom_range(0, 99) == 0) ? $urandom_range(1, FRAME_WIDTH - 1)
                                        : $urandom_range(1, 12);
    v = $urandom_range(0, 1) ? int'(c) + span : int'(c) - span;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return X_W'(v);
  endfunction

  function automatic logic [Y_W-1:0] near_row(input logic [Y_W-1:0] r);
    int span;
    int v;
    span = ($urandom_range(0, 19) == 0) ? $urandom_range(1, FRAME_HEIGHT - 1)
                                        : $urandom_range(1, 12);
    v = $urandom_range(0, 1) ? int'(r) + span : int'(r) - span;
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return Y_W'(v);
  endfunction

  // Every field random over its whole width; advance words carry this as junk.
  function automatic item_word_t noise_word(input logic op);
    item_word_t w;
    w.op = op;
    w.xs = pick_col();
    w.ys = pick_row();
    w.xe = pick_col();
    w.ye = pick_row();
    w.r  = C_W'($urandom);
    w.g  = C_W'($urandom);
    w.b  = C_W'($urandom);
    return w;
  endfunction

  // Presents one word after an optional gap and returns at the rising edge that
  // takes it. The handshake is sampled at the falling edge, where valid and
  // ready are both settled, so the decision never races the clock edge.
  task automatic send_word(input item_word_t w);
    int gap;
    bit taken;
    gap = pick_idle();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.operation <= w.op;
    item_bus.x_start   <= w.xs;
    item_bus.y_start   <= w.ys;
    item_bus.x_end     <= w.xe;
    item_bus.y_end     <= w.ye;
    item_bus.red_in    <= w.r;
    item_bus.green_in  <= w.g;
    item_bus.blue_in   <= w.b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (item_bus.valid === 1'b1) && (item_bus.ready === 1'b1);
      @(posedge clk_i);
    end
  endtask

  // Sends a word, steps the predictor and files what the core must produce.
  task automatic apply_word(input item_word_t w, input row_kind_e kind,
                            input pixel_word_t typed);
    pixel_word_t px;
    bit          made;
    send_word(w);
    made = rasterize_step(w, px);
    if (made) pixel_words++;
    case (kind)
      ROW_TYPED:   pixels_due = {pixels_due, typed};
      ROW_PREDICT: if (made) pixels_due = {pixels_due, px};
      default: ;
    endcase
  endtask

  // The random part is mostly whole lines: a start followed by advances up to
  // the flagged last pixel. Some lines are cut short by the next start, some
  // are followed by advances that must be dropped, and now and then a fully
  // random word goes in. Most lines are short so that many shapes get covered.
  task automatic random_lines();
    item_word_t w;
    int         shape_pick;
    int         cut;
    int         sent;
    while (pixel_words < PIXEL_WORDS_WANTED) begin
      calm_phase = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        apply_word(noise_word(1'($urandom_range(0, 1))), ROW_PREDICT, '0);
        continue;
      end
      w = noise_word(OPERATION_START);
      shape_pick = $urandom_range(0, 99);
      if (shape_pick < 8) begin
        w.xe = w.xs;
        w.ye = w.ys;
      end else if (shape_pick < 22) begin
        w.xe = w.xs;
        w.ye = near_row(w.ys);
      end else begin
        // Shallow lines, or steep ones that leave gaps in the rows.
        w.xe = near_col(w.xs);
        if ($urandom_range(0, 1)) w.ye = near_row(w.ys);
      end
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : -1;
      apply_word(w, ROW_PREDICT, '0);
      sent = 0;
      while (line_on && sent != cut) begin
        apply_word(noise_word(OPERATION_ADVANCE), ROW_PREDICT, '0);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) apply_word(noise_word(OPERATION_ADVANCE), ROW_PREDICT, '0);
      end
    end
  endtask

  // Stimulus: reset, the directed rows, then the random lines, then the drain.
  initial begin
    pixel_word_t typed;

    rst_ni             <= 1'b0;
    item_bus.valid     <= 1'b0;
    item_bus.operation <= OPERATION_START;
    item_bus.x_start   <= '0;
    item_bus.y_start   <= '0;
    item_bus.x_end     <= '0;
    item_bus.y_end     <= '0;
    item_bus.red_in    <= '0;
    item_bus.green_in  <= '0;
    item_bus.blue_in   <= '0;

    // Directed rows: an advance straight after reset, single points at both
    // corners and with every endpoint saturated, a steep line with gaps walked
    // to its end and one advance beyond it, a vertical line given bottom-up,
    // a start dropping a running line, a reversed full-frame diagonal,
    // columns beyond the frame on a sloped line, a vertical line whose rows
    // saturate, and an off-frame column that saturates into a vertical line.
    directed_rows = '{
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_SILENT, 0, 0, 0},
      '{'{OPERATION_START, 0, 0, 0, 0, 0, 0, 0}, ROW_TYPED, 0, 0, 1},
      '{'{OPERATION_ADVANCE, 1023, 511, 1023, 511, 255, 255, 255}, ROW_SILENT, 0, 0, 0},
      '{'{OPERATION_START, 639, 479, 639, 479, 255, 255, 255}, ROW_TYPED, 639, 479, 1},
      '{'{OPERATION_START, 1023, 511, 1023, 511, 170, 85, 15}, ROW_TYPED, 639, 479, 1},
      '{'{OPERATION_START, 0, 0, 3, 479, 18, 52, 86}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 1023, 0, 0, 511, 0, 255, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 511, 1023, 0, 255, 0, 255}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 512, 256, 512, 256, 128, 128, 128}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_SILENT, 0, 0, 0},
      '{'{OPERATION_START, 5, 10, 5, 7, 1, 2, 3}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_START, 10, 0, 0, 479, 200, 100, 50}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_START, 639, 0, 0, 479, 7, 8, 9}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_START, 700, 300, 630, 100, 33, 66, 99}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_START, 100, 500, 100, 470, 1, 1, 1}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_START, 1023, 0, 639, 5, 254, 253, 252}, ROW_PREDICT, 0, 0, 0},
      '{'{OPERATION_ADVANCE, 0, 0, 0, 0, 0, 0, 0}, ROW_PREDICT, 0, 0, 0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      typed = '{directed_rows[k].px, directed_rows[k].py, directed_rows[k].w.r,
                directed_rows[k].w.g, directed_rows[k].w.b, directed_rows[k].plast};
      apply_word(directed_rows[k].w, directed_rows[k].kind, typed);
    end

    random_lines();
    item_bus.valid <= 1'b0;
    calm_phase = 1'b0;

    // Wait for every pixel still owed, then give the core time to show any
    // extra pixel it should not produce.
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("line_rasterizer_core_test passed");
    end else begin
      $display("line_rasterizer_core_test failed");
    end
    $finish;
  end

  // Pixel side back-pressure: ready goes high for one cycle, then a stall of
  // random length follows, which is often zero so ready stays high for runs.
  initial begin
    int hold;
    hold = 0;
    pixel_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        pixel_bus.ready <= 1'b0;
        hold--;
      end else begin
        pixel_bus.ready <= 1'b1;
        hold = pick_idle();
      end
    end
  end

  // Pixel checker: a word taken at the next rising edge is compared with the
  // oldest pixel still owed, one field at a time.
  initial begin
    pixel_word_t got;
    pixel_word_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1) begin
        got = '{pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.red_out,
                pixel_bus.green_out, pixel_bus.blue_out, pixel_bus.last_pixel};
        if (pixels_due.size() == 0) begin
          flag_mismatch($sformatf("pixel (%0d,%0d) with none owed", got.x, got.y));
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x)
            flag_mismatch($sformatf("pixel_x %0d, expected %0d", got.x, want.x));
          if (got.y !== want.y)
            flag_mismatch($sformatf("pixel_y %0d, expected %0d", got.y, want.y));
          if (got.r !== want.r)
            flag_mismatch($sformatf("red_out %0d, expected %0d", got.r, want.r));
          if (got.g !== want.g)
            flag_mismatch($sformatf("green_out %0d, expected %0d", got.g, want.g));
          if (got.b !== want.b)
            flag_mismatch($sformatf("blue_out %0d, expected %0d", got.b, want.b));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last_pixel %0b, expected %0b", got.last, want.last));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("line_rasterizer_core_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lr_pkg.sv
rtl/core/lr_if.sv
rtl/core/lr_sequencer.sv
rtl/core/line_rasterizer_core.sv
rtl/core/lr_checker.sv
dv/line_rasterizer_core_test.sv
